// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/core/fmrg_pkg.sv =====
// ----------------------------------------------------------------------------
// fmrg_pkg
// Shared constants, command and status types of the magnitude response block.
// ----------------------------------------------------------------------------
package fmrg_pkg;

  localparam int TABLE_SIZE_DEF = 1024;
  localparam int MAX_ORDER_DEF  = 8;

  localparam int IN_W   = 16;
  localparam int BIN_W  = 11;
  localparam int MAG_W  = 16;
  localparam int KIND_W = 2;
  localparam int ORD_W  = 5;
  localparam int CNT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 32;
  localparam int MUL_DIGITS = 3;

  localparam logic [KIND_W-1:0] KIND_BW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CB = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_STEP,
    OP_DIVM_INIT,
    OP_MUL_STEP,
    OP_BW_INIT,
    OP_BW_NEXT,
    OP_CB_INIT,
    OP_CB_NEXT,
    OP_SQ_INIT,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    FIN_IDEAL,
    FIN_ZERO,
    FIN_DIV
  } fin_t;

  typedef struct packed {
    op_t  op;
    fin_t fin;
  } cmd_t;

  typedef struct packed {
    logic             kind_bw;
    logic             kind_cb;
    logic             x_over;
    logic             pow_over;
    logic             cheb_over;
    logic [ORD_W-1:0] n_eff;
  } sts_t;

endpackage

// ===== rtl/core/fmrg_datapath.sv =====
// ----------------------------------------------------------------------------
// fmrg_datapath
// Config registers, shared divider, digit multiplier, root unit, output regs.
// ----------------------------------------------------------------------------
module fmrg_datapath #(
  parameter int  TABLE_SIZE = fmrg_pkg::TABLE_SIZE_DEF,
  parameter int  MAX_ORDER  = fmrg_pkg::MAX_ORDER_DEF,
  localparam int IDX_W      = $clog2(TABLE_SIZE),
  localparam int OUT_W      = ((fmrg_pkg::MAG_W + 2 * IDX_W + 2 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [fmrg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fmrg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [fmrg_pkg::IN_W-1:0]         in_tdata,
  input  fmrg_pkg::cmd_t                    cmd,
  output fmrg_pkg::sts_t                    sts,
  output logic [OUT_W-1:0]                  out_tdata
);

  localparam int SUM_W = (IDX_W > 11) ? IDX_W + 1 : 12;

  logic [fmrg_pkg::KIND_W-1:0] kind_r;
  logic [fmrg_pkg::BIN_W-1:0]  cutoff_r;
  logic [3:0]                  order_r;
  logic [fmrg_pkg::MAG_W-1:0]  amp_r;
  logic [fmrg_pkg::BIN_W-1:0]  center_r;

  logic [fmrg_pkg::BIN_W-1:0]  c_eff;
  logic [fmrg_pkg::ORD_W-1:0]  n_eff;
  logic [fmrg_pkg::BIN_W-1:0]  f_in;

  logic [fmrg_pkg::BIN_W-1:0]  f_r;
  logic [IDX_W-1:0]            up_idx_r, lo_idx_r;
  logic                        up_ok_r, lo_ok_r;

  logic [SUM_W-1:0]            up_sum, lo_ext;
  logic [fmrg_pkg::BIN_W-1:0]  lo_diff;
  logic                        up_ok, lo_ok;

  // divider
  logic [30:0] num_r, q_r;
  logic [31:0] den_r, rem_r;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] rem_sub;

  // multiplier
  logic [47:0] mul_a_r;
  logic [35:0] mul_b_r;
  logic [83:0] acc_r;
  logic [59:0] pprod;
  logic [23:0] x;

  // power / polynomial
  logic [47:0]        p_r;
  logic signed [34:0] prev_r, cur_r;
  logic [34:0]        cur_mag;
  logic signed [44:0] two_s, next_s;
  logic [44:0]        next_mag;

  // root
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r, sq_t;
  logic [47:0] q_sel;

  logic [fmrg_pkg::MAG_W-1:0] out_mag_r, mag_fin;
  logic [IDX_W-1:0]           out_up_idx_r, out_lo_idx_r;
  logic                       out_up_ok_r, out_lo_ok_r;

  assign f_in  = in_tdata[fmrg_pkg::BIN_W-1:0];
  assign c_eff = (cutoff_r == '0) ? fmrg_pkg::BIN_W'(1) : cutoff_r;

  always_comb begin
    if (order_r == '0) begin
      n_eff = fmrg_pkg::ORD_W'(1);
    end else if (int'(order_r) > MAX_ORDER) begin
      n_eff = fmrg_pkg::ORD_W'(MAX_ORDER);
    end else begin
      n_eff = fmrg_pkg::ORD_W'(order_r);
    end
  end

  assign up_sum  = SUM_W'(center_r) + SUM_W'(f_in);
  assign up_ok   = up_sum < SUM_W'(TABLE_SIZE);
  assign lo_diff = center_r - f_in;
  assign lo_ext  = SUM_W'(lo_diff);
  assign lo_ok   = (f_in <= center_r) && (lo_ext < SUM_W'(TABLE_SIZE));

  assign trial   = {rem_r, num_r[30]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_sub = ge ? (trial - {1'b0, den_r}) : trial;

  assign x     = q_r[23:0];
  assign pprod = mul_a_r * mul_b_r[35:24];

  assign cur_mag  = cur_r[34] ? 35'(-cur_r) : 35'(cur_r);
  assign two_s    = $signed({2'b00, acc_r[57:16], 1'b0});
  assign next_s   = (cur_r[34] ? -two_s : two_s) - 45'(prev_r);
  assign next_mag = next_s[44] ? 45'(-next_s) : 45'(next_s);

  assign q_sel = sts.kind_cb ? acc_r[65:18] : p_r;
  assign sq_t  = sq_res_r + sq_bit_r;

  always_comb begin
    case (cmd.fin)
      fmrg_pkg::FIN_IDEAL: mag_fin = (f_r < c_eff) ? amp_r : '0;
      fmrg_pkg::FIN_DIV:   mag_fin = q_r[fmrg_pkg::MAG_W-1:0];
      default:             mag_fin = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= '0;
      cutoff_r <= fmrg_pkg::BIN_W'(64);
      order_r  <= 4'd2;
      amp_r    <= fmrg_pkg::MAG_W'(4096);
      center_r <= fmrg_pkg::BIN_W'(512);
    end else if (cfg_valid) begin
      case (cfg_index)
        fmrg_pkg::REG_KIND:   kind_r   <= cfg_data[fmrg_pkg::KIND_W-1:0];
        fmrg_pkg::REG_CUTOFF: cutoff_r <= cfg_data[fmrg_pkg::BIN_W-1:0];
        fmrg_pkg::REG_ORDER:  order_r  <= cfg_data[3:0];
        fmrg_pkg::REG_AMP:    amp_r    <= cfg_data[fmrg_pkg::MAG_W-1:0];
        fmrg_pkg::REG_CENTER: center_r <= cfg_data[fmrg_pkg::BIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fmrg_pkg::OP_LOAD: begin
        f_r      <= f_in;
        up_ok_r  <= up_ok;
        lo_ok_r  <= lo_ok;
        up_idx_r <= up_ok ? up_sum[IDX_W-1:0] : '0;
        lo_idx_r <= lo_ok ? lo_ext[IDX_W-1:0] : '0;
        num_r    <= {4'b0, f_in, 16'b0};
        den_r    <= 32'(c_eff);
        rem_r    <= '0;
      end
      fmrg_pkg::OP_DIV_STEP: begin
        rem_r <= rem_sub[31:0];
        num_r <= {num_r[29:0], 1'b0};
        q_r   <= {q_r[29:0], ge};
      end
      fmrg_pkg::OP_DIVM_INIT: begin
        num_r <= {amp_r, 15'b0};
        den_r <= sq_res_r[31:0];
        rem_r <= '0;
      end
      fmrg_pkg::OP_MUL_STEP: begin
        acc_r   <= {acc_r[71:0], 12'b0} + 84'(pprod);
        mul_b_r <= {mul_b_r[23:0], 12'b0};
      end
      fmrg_pkg::OP_BW_INIT: begin
        p_r     <= 48'd65536;
        mul_a_r <= 48'd65536;
        mul_b_r <= 36'(x);
        acc_r   <= '0;
      end
      fmrg_pkg::OP_BW_NEXT: begin
        p_r     <= acc_r[63:16];
        mul_a_r <= acc_r[63:16];
        mul_b_r <= 36'(x);
        acc_r   <= '0;
      end
      fmrg_pkg::OP_CB_INIT: begin
        prev_r  <= 35'sd65536;
        cur_r   <= $signed(35'(x));
        mul_a_r <= 48'(x);
        mul_b_r <= 36'(x);
        acc_r   <= '0;
      end
      fmrg_pkg::OP_CB_NEXT: begin
        prev_r  <= cur_r;
        cur_r   <= next_s[34:0];
        mul_a_r <= 48'(next_mag[32:0]);
        mul_b_r <= 36'(x);
        acc_r   <= '0;
      end
      fmrg_pkg::OP_SQ_INIT: begin
        mul_a_r <= 48'(cur_mag[32:0]);
        mul_b_r <= 36'(cur_mag[32:0]);
        acc_r   <= '0;
      end
      fmrg_pkg::OP_SQRT_INIT: begin
        sq_v_r   <= {1'b0, 49'(q_sel) + 49'd65536, 14'b0};
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      fmrg_pkg::OP_SQRT_STEP: begin
        if (sq_v_r >= sq_t) begin
          sq_v_r   <= sq_v_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      fmrg_pkg::OP_FINISH: begin
        out_mag_r    <= mag_fin;
        out_up_idx_r <= up_idx_r;
        out_up_ok_r  <= up_ok_r;
        out_lo_idx_r <= lo_idx_r;
        out_lo_ok_r  <= lo_ok_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.kind_bw   = kind_r == fmrg_pkg::KIND_BW;
    sts.kind_cb   = kind_r == fmrg_pkg::KIND_CB;
    sts.x_over    = |q_r[30:24];
    sts.pow_over  = |acc_r[83:64];
    sts.cheb_over = |next_mag[44:33];
    sts.n_eff     = n_eff;
  end

  assign out_tdata = OUT_W'({out_lo_ok_r, out_lo_idx_r, out_up_ok_r, out_up_idx_r, out_mag_r});

endmodule

// ===== rtl/core/fmrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmrg_ctrl
// Sequencer for division, power / recurrence, root and output hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmrg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  fmrg_pkg::sts_t sts,
  output fmrg_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_X, S_CHECK, S_MUL, S_BW_NEXT, S_CB_NEXT, S_SQ_LOAD,
    S_SQRT_INIT, S_SQRT, S_DIVM_INIT, S_DIVM, S_DONE
  } state_t;

  typedef enum logic [1:0] {T_BW, T_CB, T_SQ} tag_t;

  localparam int CW = fmrg_pkg::CNT_W;

  state_t               state_r, state_nxt;
  tag_t                 tag_r, tag_nxt;
  fmrg_pkg::fin_t       fin_r, fin_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [1:0]           mcnt_r, mcnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CW-1:0]        cnt_inc, n_two, n_m1;

  assign cnt_inc    = cnt_r + CW'(1);
  assign n_two      = {sts.n_eff, 1'b0};
  assign n_m1       = CW'(sts.n_eff) - CW'(1);
  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    tag_nxt       = tag_r;
    fin_nxt       = fin_r;
    cnt_nxt       = cnt_r;
    mcnt_nxt      = mcnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = fmrg_pkg::OP_NONE;
    cmd.fin       = fin_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op  = fmrg_pkg::OP_LOAD;
          cnt_nxt = '0;
          if (sts.kind_bw || sts.kind_cb) begin
            state_nxt = S_DIV_X;
          end else begin
            fin_nxt   = fmrg_pkg::FIN_IDEAL;
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV_X: begin
        cmd.op  = fmrg_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_inc;
        if (cnt_r == CW'(fmrg_pkg::DIV_STEPS - 1)) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (sts.x_over) begin
          fin_nxt   = fmrg_pkg::FIN_ZERO;
          state_nxt = S_DONE;
        end else if (sts.kind_bw) begin
          cmd.op    = fmrg_pkg::OP_BW_INIT;
          tag_nxt   = T_BW;
          state_nxt = S_MUL;
        end else begin
          cmd.op = fmrg_pkg::OP_CB_INIT;
          if (sts.n_eff == fmrg_pkg::ORD_W'(1)) begin
            state_nxt = S_SQ_LOAD;
          end else begin
            tag_nxt   = T_CB;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.op   = fmrg_pkg::OP_MUL_STEP;
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'(fmrg_pkg::MUL_DIGITS - 1)) begin
          mcnt_nxt = '0;
          case (tag_r)
            T_BW:    state_nxt = S_BW_NEXT;
            T_CB:    state_nxt = S_CB_NEXT;
            default: state_nxt = S_SQRT_INIT;
          endcase
        end
      end
      S_BW_NEXT: begin
        if (sts.pow_over) begin
          fin_nxt   = fmrg_pkg::FIN_ZERO;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = fmrg_pkg::OP_BW_NEXT;
          cnt_nxt   = cnt_inc;
          state_nxt = (cnt_inc == n_two) ? S_SQRT_INIT : S_MUL;
        end
      end
      S_CB_NEXT: begin
        if (sts.cheb_over) begin
          fin_nxt   = fmrg_pkg::FIN_ZERO;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = fmrg_pkg::OP_CB_NEXT;
          cnt_nxt   = cnt_inc;
          state_nxt = (cnt_inc == n_m1) ? S_SQ_LOAD : S_MUL;
        end
      end
      S_SQ_LOAD: begin
        cmd.op    = fmrg_pkg::OP_SQ_INIT;
        tag_nxt   = T_SQ;
        state_nxt = S_MUL;
      end
      S_SQRT_INIT: begin
        cmd.op    = fmrg_pkg::OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = fmrg_pkg::OP_SQRT_STEP;
        cnt_nxt = cnt_inc;
        if (cnt_r == CW'(fmrg_pkg::SQRT_STEPS - 1)) state_nxt = S_DIVM_INIT;
      end
      S_DIVM_INIT: begin
        cmd.op    = fmrg_pkg::OP_DIVM_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIVM;
      end
      S_DIVM: begin
        cmd.op  = fmrg_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_inc;
        if (cnt_r == CW'(fmrg_pkg::DIV_STEPS - 1)) begin
          fin_nxt   = fmrg_pkg::FIN_DIV;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = fmrg_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tag_r       <= T_BW;
      fin_r       <= fmrg_pkg::FIN_IDEAL;
      cnt_r       <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tag_r       <= tag_nxt;
      fin_r       <= fin_nxt;
      cnt_r       <= cnt_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_PROP(a_accept_busy, clk, rst_n, (in_tvalid && in_tready) |=> (state_r != S_IDLE), "item accepted but sequencer stayed idle")
  `ASSERT_PROP(a_result_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result raised outside done state")
  `ASSERT_NEVER(a_no_overwrite, clk, rst_n, out_valid_r && !out_tready && (cmd.op == fmrg_pkg::OP_FINISH), "held result overwritten")

endmodule

// ===== rtl/core/filter_magnitude_response_gen_top.sv =====
// The ideal kind needs only the load and done states; Butterworth and Chebyshev end early
// when the ratio or the response overflows and the magnitude is flushed to zero.
// One item in flight; the next is taken the cycle after its result enters the output register.
// Cost is set by the radix-2 divider (used for the ratio and for the final quotient), the
// bit-serial root and the 48x12 digit multiplier.
// Reset (rst_n low, synchronous) restores default registers and empties the output register.
// ----------------------------------------------------------------------------
// filter_magnitude_response_gen_top
// Low-pass magnitude for one bin offset plus the two mirrored table addresses.
// ----------------------------------------------------------------------------
module filter_magnitude_response_gen_top #(
  parameter int  TABLE_SIZE = fmrg_pkg::TABLE_SIZE_DEF,
  parameter int  MAX_ORDER  = fmrg_pkg::MAX_ORDER_DEF,
  localparam int IDX_W      = $clog2(TABLE_SIZE),
  localparam int OUT_W      = ((fmrg_pkg::MAG_W + 2 * IDX_W + 2 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fmrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmrg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fmrg_pkg::IN_W-1:0]       in_tdata,   // bin_offset
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata   // magnitude, upper_index, upper_valid,
                                                      // lower_index, lower_valid
);

  fmrg_pkg::cmd_t cmd;
  fmrg_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  fmrg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fmrg_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_ORDER  (MAX_ORDER)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
